@@ hw/rtl/igmp_querier_group_table_defines.svh @@
//------------------------------------------------------------------------------
// IGMP querier assertion macros
// Assertion macros shared by the RTL of the IGMP querier group table.
//------------------------------------------------------------------------------
`ifndef IGMP_QUERIER_GROUP_TABLE_DEFINES_SVH
`define IGMP_QUERIER_GROUP_TABLE_DEFINES_SVH

// Checks that a condition holds at every clock edge out of reset.
`define IGQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define IGQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/igmpq_pkg.sv @@
//------------------------------------------------------------------------------
// IGMP querier package
// Types, codes and timing constants shared by the group table RTL.
//------------------------------------------------------------------------------
package igmpq_pkg;

  localparam int GROUP_ENTRIES = 16;
  localparam int IDX_W = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;

  localparam logic [11:0] MEMBERSHIP_TICKS    = 12'd2600;
  localparam logic [11:0] OTHER_QUERIER_TICKS = 12'd2550;
  localparam logic [11:0] STARTUP_TICKS       = 12'd310;
  localparam logic [11:0] QUERY_TICKS         = 12'd1250;
  localparam logic [11:0] LEAVE_TICKS         = 12'd2;
  localparam logic [7:0]  GENERAL_RESP_CODE   = 8'd100;
  localparam logic [7:0]  GROUP_RESP_CODE     = 8'd10;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_STOP    = 3'd1,
    EV_GENERAL = 3'd2,
    EV_GROUPQ  = 3'd3,
    EV_FULL    = 3'd4
  } event_t;

  localparam logic [2:0] REC_JOIN_A = 3'd2;
  localparam logic [2:0] REC_LEAVE  = 3'd3;
  localparam logic [2:0] REC_JOIN_B = 3'd4;

  localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] REG_GROUP_LOW  = 2'd1;
  localparam logic [1:0] REG_GROUP_HIGH = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WALK  = 2'd1,
    S_ALLOC = 2'd2,
    S_FLUSH = 2'd3
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] group;
    logic [31:0] reporter;
    logic [11:0] timeout;
    logic        retransmit;
    logic        streaming;
  } entry_t;

endpackage

@@ hw/rtl/igmpq_if.sv @@
//------------------------------------------------------------------------------
// IGMP querier channels
// Valid/ready channels for input words and result words.
//------------------------------------------------------------------------------
interface igmpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  record_type;
  logic [31:0] group_addr;
  logic [31:0] sender_addr;

  modport source (output valid, command, record_type, group_addr, sender_addr,
                  input ready);
  modport sink (input valid, command, record_type, group_addr, sender_addr,
                output ready);
endinterface

interface igmpq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] event_group;
  logic [7:0]  max_resp_code;
  logic        is_querier;
  logic        last;

  modport source (output valid, event_res, event_group, max_resp_code, is_querier,
                  last, input ready);
  modport sink (input valid, event_res, event_group, max_resp_code, is_querier,
                last, output ready);
endinterface

@@ hw/rtl/igmp_querier_group_table.sv @@
//------------------------------------------------------------------------------
// IGMP querier group table
// Querier election, general-query timing and a ring of group entry cells.
//------------------------------------------------------------------------------
// Channel   Direction  Word contents
// in_ch     sink       command, record_type, group_addr, sender_addr
// out_ch    source     event_res, event_group, max_resp_code, is_querier, last
//
// A query word, an ignored command and an out-of-range or ignored report are
// handled in idle without a walk. A tick walks the ring once; a join for a new
// group walks it to search and, if a cell is free, again to allocate it; a join
// for a known group or a leave walks it once. The ring rotates one cell per
// cycle, unless held by a stalled output, past a single update unit at its head.
// Reset is synchronous and clears the cell valid bits and the querier state.
// A stalled output holds the ring only in a cycle that must emit a result.
//------------------------------------------------------------------------------
`include "igmp_querier_group_table_defines.svh"

module igmp_querier_group_table (
  input  logic        clk,
  input  logic        rst,
  igmpq_in_if.sink    in_ch,
  igmpq_out_if.source out_ch,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [31:0] write_data
);
  import igmpq_pkg::*;

  // Configuration registers.
  logic [31:0] local_addr;
  logic [31:0] group_low;
  logic [31:0] group_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= 32'h0000_0000;
      group_low  <= 32'hE000_0000;
      group_high <= 32'hEFFF_FFFF;
    end else if (write_en) begin
      unique case (write_index)
        REG_LOCAL_ADDR: local_addr <= write_data;
        REG_GROUP_LOW:  group_low  <= write_data;
        REG_GROUP_HIGH: group_high <= write_data;
        default: ;
      endcase
    end
  end

  // Control state.
  state_t      state, state_next;
  logic        querier;
  logic [1:0]  startup_left;
  logic [11:0] general_timer;
  logic [IDX_W-1:0] cnt;
  logic        tick_op;
  logic        is_join;
  logic        found;
  logic        free_found;
  logic [IDX_W-1:0] free_idx;
  logic [31:0] key_group;
  logic [31:0] key_sender;

  // Pending result: held until the next one shows whether it was the last.
  logic        pend_valid;
  logic [2:0]  pend_ev;
  logic [31:0] pend_group;
  logic [7:0]  pend_code;

  // Output register.
  logic        out_valid;
  logic [2:0]  out_ev;
  logic [31:0] out_group;
  logic [7:0]  out_code;
  logic        out_q;
  logic        out_last;

  // Entry ring: cell 0 is the head seen by the update logic, and the updated
  // head enters at the tail, so after a full turn the order is restored.
  entry_t cells [GROUP_ENTRIES];
  entry_t head, head_next;
  logic   shift;

  for (genvar k = 0; k < GROUP_ENTRIES; k++) begin : g_ring
    entry_t cin;
    if (k == GROUP_ENTRIES - 1) begin : g_tail
      assign cin = head_next;
    end else begin : g_mid
      assign cin = cells[k+1];
    end
    igmpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .entry_in  (cin),
      .entry_out (cells[k])
    );
  end

  assign head = cells[0];

  logic accept;
  logic out_free;
  logic in_range;
  logic walk_end;
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_range = (in_ch.group_addr >= group_low) && (in_ch.group_addr <= group_high);
  assign walk_end = (cnt == IDX_W'(GROUP_ENTRIES - 1));
  assign in_ch.ready = (state == S_IDLE);

  // Update of the head entry for the current pass.
  logic        step_emit;
  logic [2:0]  step_ev;
  logic [7:0]  step_code;
  logic        step_hit;
  logic        step_free;
  logic [11:0] tdec;
  logic        emit_ok;

  always_comb begin
    head_next = head;
    step_emit = 1'b0;
    step_ev   = EV_START;
    step_code = 8'd0;
    step_hit  = head.valid && (head.group == key_group);
    step_free = !head.valid;
    tdec      = (head.timeout != 12'd0) ? head.timeout - 12'd1 : head.timeout;
    if (state == S_ALLOC) begin
      if (cnt == free_idx) begin
        head_next.valid      = 1'b1;
        head_next.group      = key_group;
        head_next.streaming  = 1'b1;
        head_next.timeout    = MEMBERSHIP_TICKS;
        head_next.retransmit = 1'b0;
        head_next.reporter   = key_sender;
        step_emit = 1'b1;
        step_ev   = EV_START;
      end
    end else if (state == S_WALK) begin
      if (found == 1'b0 && is_join && step_hit) begin
        head_next.streaming  = 1'b1;
        head_next.timeout    = MEMBERSHIP_TICKS;
        head_next.retransmit = 1'b0;
        head_next.reporter   = key_sender;
        step_emit = !head.streaming;
        step_ev   = EV_START;
      end
    end
    if (state == S_WALK && tick_op) begin
      if (head.valid) begin
        head_next.timeout = tdec;
        if (tdec == 12'd0) begin
          step_emit = head.streaming;
          step_ev   = EV_STOP;
          head_next.valid      = 1'b0;
          head_next.streaming  = 1'b0;
          head_next.retransmit = 1'b0;
        end else if (querier && head.retransmit) begin
          step_emit = 1'b1;
          step_ev   = EV_GROUPQ;
          step_code = GROUP_RESP_CODE;
        end
      end
    end else if (state == S_WALK && !is_join) begin
      if (step_hit && head.reporter == key_sender) begin
        head_next.timeout    = LEAVE_TICKS;
        head_next.reporter   = 32'd0;
        head_next.retransmit = 1'b1;
        step_emit = querier;
        step_ev   = EV_GROUPQ;
        step_code = GROUP_RESP_CODE;
      end
    end
    emit_ok = !step_emit || !pend_valid || out_free;
  end

  assign shift = ((state == S_WALK) || (state == S_ALLOC)) && emit_ok;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_ch.command == CMD_TICK ||
            (in_ch.command == CMD_REPORT && in_range &&
             (in_ch.record_type == REC_JOIN_A || in_ch.record_type == REC_JOIN_B ||
              in_ch.record_type == REC_LEAVE)))) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (shift && walk_end) begin
          if (!tick_op && is_join && !found && !(step_hit) && (free_found || step_free))
            state_next = S_ALLOC;
          else
            state_next = S_FLUSH;
        end
      end
      S_ALLOC: begin
        if (shift && walk_end) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Querier, timers and pass bookkeeping.
  logic [11:0] gt_dec;
  assign gt_dec = (general_timer != 12'd0) ? general_timer - 12'd1 : general_timer;

  logic pend_push;
  logic full_event;
  assign pend_push  = shift && step_emit;
  assign full_event = (state == S_WALK) && shift && walk_end && !tick_op && is_join &&
                      !found && !step_hit && !free_found && !step_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      querier       <= 1'b1;
      startup_left  <= 2'd2;
      general_timer <= 12'd0;
      pend_valid    <= 1'b0;
      cnt           <= '0;
      tick_op       <= 1'b0;
      is_join       <= 1'b0;
      found         <= 1'b0;
      free_found    <= 1'b0;
    end else begin
      if (accept) begin
        cnt        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
        tick_op    <= (in_ch.command == CMD_TICK);
        // Only a report record can be a join; ticks carry arbitrary fields.
        is_join    <= (in_ch.command == CMD_REPORT) &&
                      ((in_ch.record_type == REC_JOIN_A) ||
                       (in_ch.record_type == REC_JOIN_B));
        unique case (in_ch.command)
          CMD_TICK: begin
            if (gt_dec == 12'd0) begin
              pend_valid <= 1'b1;
              querier    <= 1'b1;
              if (startup_left != 2'd0) begin
                general_timer <= STARTUP_TICKS;
                startup_left  <= startup_left - 2'd1;
              end else begin
                general_timer <= QUERY_TICKS;
              end
            end else begin
              general_timer <= gt_dec;
            end
          end
          CMD_QUERY: begin
            if (in_ch.sender_addr < local_addr) begin
              querier       <= 1'b0;
              startup_left  <= 2'd0;
              general_timer <= OTHER_QUERIER_TICKS;
            end
          end
          CMD_REPORT, CMD_NONE: ;
          default: ;
        endcase
      end else if (shift) begin
        cnt <= walk_end ? '0 : cnt + IDX_W'(1);
        if (state == S_WALK && step_hit) found <= 1'b1;
        if (state == S_WALK && step_free && !free_found) free_found <= 1'b1;
        if (pend_push) pend_valid <= 1'b1;
        if (full_event) pend_valid <= 1'b1;
      end else if (state == S_FLUSH && pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_group  <= in_ch.group_addr;
      key_sender <= in_ch.sender_addr;
      pend_ev    <= EV_GENERAL;
      pend_group <= 32'd0;
      pend_code  <= GENERAL_RESP_CODE;
    end else begin
      if (state == S_WALK && shift && step_free && !free_found) free_idx <= cnt;
      if (pend_push) begin
        pend_ev    <= step_ev;
        pend_group <= head.group;
        pend_code  <= step_code;
        if (state == S_ALLOC) pend_group <= key_group;
      end
      if (full_event) begin
        pend_ev    <= EV_FULL;
        pend_group <= key_group;
        pend_code  <= 8'd0;
      end
    end
  end

  // Output register: a pending word moves out when a newer one arrives
  // (not last) or at the end of the pass (last).
  logic out_load_mid;
  logic out_load_last;
  assign out_load_mid  = pend_push && pend_valid;
  assign out_load_last = (state == S_FLUSH) && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_mid || out_load_last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_mid || out_load_last) begin
      out_ev    <= pend_ev;
      out_group <= pend_group;
      out_code  <= pend_code;
      out_q     <= querier;
      out_last  <= out_load_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.event_res     = out_ev;
  assign out_ch.event_group   = out_group;
  assign out_ch.max_resp_code = out_code;
  assign out_ch.is_querier    = out_q;
  assign out_ch.last          = out_last;

  `IGQ_ASSERT_ALWAYS(a_idle_no_pending, !(state == S_IDLE && pend_valid),
    "pending result left over in idle")
  `IGQ_ASSERT_ALWAYS(a_startup_querier, (startup_left == 2'd0) || querier,
    "startup queries left while not querier")
  `IGQ_ASSERT_NEXT(a_tick_walks, accept && in_ch.command == CMD_TICK, state == S_WALK,
    "tick did not start a table walk")

endmodule

@@ hw/rtl/igmpq_cell.sv @@
//------------------------------------------------------------------------------
// IGMP querier table cell
// Holds one group entry and passes it to its neighbor when the ring rotates.
//------------------------------------------------------------------------------
module igmpq_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  igmpq_pkg::entry_t entry_in,
  output igmpq_pkg::entry_t entry_out
);
  import igmpq_pkg::*;

  entry_t entry;

  // Only the valid bit is cleared; the rest is loaded from entry_in on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= entry_in.valid;
    end
    if (shift) begin
      entry.group      <= entry_in.group;
      entry.reporter   <= entry_in.reporter;
      entry.timeout    <= entry_in.timeout;
      entry.retransmit <= entry_in.retransmit;
      entry.streaming  <= entry_in.streaming;
    end
  end

  assign entry_out = entry;

endmodule
